/* src/quartet_topology_vote_counter_macros.svh */
// Assertion macros used by the RTL file that carries checks.
// Each check is sampled on the rising edge of clk and is held off while rst_n is low.
`ifndef QUARTET_TOPOLOGY_VOTE_COUNTER_MACROS_SVH
`define QUARTET_TOPOLOGY_VOTE_COUNTER_MACROS_SVH

`ifndef ASSERT_OFF

// Same-cycle implication.
`define QTVC_ASSERT_IMPLIES(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("same-cycle check failed");

// Next-cycle implication.
`define QTVC_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("next-cycle check failed");

`else

`define QTVC_ASSERT_IMPLIES(label, ante, cons)
`define QTVC_ASSERT_NEXT(label, ante, cons)

`endif

`endif

/* src/qtvc_pkg.sv */
package qtvc_pkg;

    localparam int ID_W       = 6;
    localparam int TAXA_CNT_W = 6;
    localparam int N_W        = ID_W + 1;
    localparam int RANK_OUT_W = 16;
    localparam int CNT_OUT_W  = 16;
    localparam int TOPO_W     = 2;

    typedef logic [ID_W-1:0]   taxon_id_t;
    typedef logic [TOPO_W-1:0] topo_t;

    localparam topo_t TOPO_DISJOINT    = 2'd0;
    localparam topo_t TOPO_INTERLEAVED = 2'd1;
    localparam topo_t TOPO_NESTED      = 2'd2;
    localparam topo_t WIN_TIE          = 2'd3;

    localparam logic MODE_RECORD = 1'b0;
    localparam logic MODE_QUERY  = 1'b1;

    localparam logic [TAXA_CNT_W-1:0] TAXA_COUNT_RESET = 6'd32;

    typedef enum logic [5:0] {
        ST_IDLE = 6'b000001,
        ST_SORT = 6'b000010,
        ST_RANK = 6'b000100,
        ST_READ = 6'b001000,
        ST_MOD  = 6'b010000,
        ST_OUT  = 6'b100000
    } state_t;

    // Binomial coefficient C(m,k) for k up to 4; evaluated at elaboration only.
    function automatic longint choose_k(input int m, input int k);
        longint mm;
        longint r;
        mm = longint'(m);
        r  = 0;
        if (m >= k) begin
            case (k)
                1: r = mm;
                2: r = mm * (mm - 1) / 2;
                3: r = mm * (mm - 1) * (mm - 2) / 6;
                4: r = mm * (mm - 1) * (mm - 2) * (mm - 3) / 24;
                default: r = 0;
            endcase
        end
        return r;
    endfunction

endpackage

/* src/qtvc_rank.sv */
module qtvc_rank #(
    parameter int MAX_TAXA = 32
) (
    input  logic [qtvc_pkg::N_W-1:0] n,
    input  qtvc_pkg::taxon_id_t      sorted_ids [4],
    output logic [$clog2(MAX_TAXA*(MAX_TAXA-1)*(MAX_TAXA-2)*(MAX_TAXA-3)/24+1)-1:0] rank
);
    import qtvc_pkg::*;

    localparam int QUARTETS = MAX_TAXA * (MAX_TAXA - 1) * (MAX_TAXA - 2) * (MAX_TAXA - 3) / 24;
    localparam int RANK_W   = $clog2(QUARTETS + 1);
    localparam int IDX_W    = $clog2(MAX_TAXA);

    // Row k-1 holds C(m,k) for m = 0 .. MAX_TAXA-1.
    logic [RANK_W-1:0] c_tab [4][MAX_TAXA];
    logic [N_W-1:0]    diff  [4];
    logic [RANK_W+1:0] sum;

    for (genvar k = 1; k <= 4; k++) begin : g_row
        for (genvar m = 0; m < MAX_TAXA; m++) begin : g_col
            assign c_tab[k-1][m] = RANK_W'(choose_k(m, k));
        end
    end

    // Term i takes C(n - x_i, 4 - i).
    always_comb
    begin
        sum = '0;
        for (int i = 0; i < 4; i++)
        begin
            diff[i] = n - {1'b0, sorted_ids[i]};
            sum     = sum + (RANK_W+2)'(c_tab[3-i][diff[i][IDX_W-1:0]]);
        end
    end

    assign rank = sum[RANK_W-1:0];

endmodule

/* src/quartet_topology_vote_counter.sv */
// Quartet topology vote counter.
// Input: pulse start with mode and four taxon ids while busy is low; the item
// transfers at that edge. Record mode (mode 0) adds one saturating vote for the
// split (a,b)|(c,d) to its quartet; query mode (mode 1) only reads the votes.
// Output: done is high for exactly one cycle with quartet_rank, topology, the
// three counts, winner and bad_input; the result transfers at the edge that ends
// that cycle. The receiver cannot stall, so results are never held back.
// Configuration: taxa_count transfers on cfg_valid && cfg_ready; cfg_ready is
// always high. Write it only while no item is in flight.
// Sequencing: the sequencer steps a valid item through sort, rank, memory read,
// read-modify-write and output on the counter memory, one item at a time, and the
// next item can transfer at the edge at which the result transfers. An item with
// bad ids goes from sort straight to output and does not touch the memory.
// Reset: taxa_count returns to 32 and a clearing pass zeroes the counter memory,
// one entry per cycle, all C(MAX_TAXA,4) entries (35960 at the default); busy stays
// high for the whole pass.
`include "quartet_topology_vote_counter_macros.svh"

module quartet_topology_vote_counter #(
    parameter int MAX_TAXA   = 32,
    parameter int COUNT_BITS = 16
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                start,
    output logic                                busy,
    input  logic                                mode,
    input  logic [qtvc_pkg::ID_W-1:0]           taxon_a,
    input  logic [qtvc_pkg::ID_W-1:0]           taxon_b,
    input  logic [qtvc_pkg::ID_W-1:0]           taxon_c,
    input  logic [qtvc_pkg::ID_W-1:0]           taxon_d,
    input  logic                                cfg_valid,
    output logic                                cfg_ready,
    input  logic [qtvc_pkg::TAXA_CNT_W-1:0]     cfg_data,
    output logic                                done,
    output logic [qtvc_pkg::RANK_OUT_W-1:0]     quartet_rank,
    output logic [qtvc_pkg::TOPO_W-1:0]         topology,
    output logic [qtvc_pkg::CNT_OUT_W-1:0]      count_first,
    output logic [qtvc_pkg::CNT_OUT_W-1:0]      count_second,
    output logic [qtvc_pkg::CNT_OUT_W-1:0]      count_third,
    output logic [qtvc_pkg::TOPO_W-1:0]         winner,
    output logic                                bad_input
);
    import qtvc_pkg::*;

    localparam int QUARTETS = MAX_TAXA * (MAX_TAXA - 1) * (MAX_TAXA - 2) * (MAX_TAXA - 3) / 24;
    localparam int RANK_W   = $clog2(QUARTETS + 1);
    localparam int MEM_W    = 3 * COUNT_BITS;

    localparam logic [COUNT_BITS-1:0] COUNT_MAX  = '1;
    localparam logic [N_W-1:0]        N_MAX      = N_W'(MAX_TAXA);
    localparam logic [RANK_W-1:0]     LAST_ENTRY = RANK_W'(QUARTETS - 1);

    // Control state
    state_t                 state_reg, state_next;
    logic                   clearing_reg;
    logic [RANK_W-1:0]      clr_addr_reg;
    logic [TAXA_CNT_W-1:0]  taxa_count_reg;
    logic                   done_reg;

    // Item payload, one item in flight
    logic                   mode_reg;
    taxon_id_t              x_reg [4];
    taxon_id_t              s_reg [4];
    topo_t                  topo_reg;
    logic                   bad_reg;
    logic [RANK_W-1:0]      rank_reg;
    logic [MEM_W-1:0]       rdata_reg;
    logic [COUNT_BITS-1:0]  cnt_reg [3];

    // Result registers
    logic [RANK_OUT_W-1:0]  quartet_rank_reg;
    topo_t                  topology_reg;
    logic [CNT_OUT_W-1:0]   count_first_reg;
    logic [CNT_OUT_W-1:0]   count_second_reg;
    logic [CNT_OUT_W-1:0]   count_third_reg;
    topo_t                  winner_reg;
    logic                   bad_input_reg;

    // Counter memory: three counters per quartet, topology 0 in the low slice
    logic [MEM_W-1:0]       vote_mem [0:QUARTETS-1];

    logic                   accept;
    logic [N_W-1:0]         n_eff;
    taxon_id_t              st1 [4];
    taxon_id_t              st2 [4];
    taxon_id_t              srt [4];
    topo_t                  topo_comb;
    logic                   bad_comb;
    logic [RANK_W-1:0]      rank_comb;
    logic [COUNT_BITS-1:0]  rd_cnt  [3];
    logic [COUNT_BITS-1:0]  new_cnt [3];
    topo_t                  win_comb;
    logic                   mem_we;
    logic [RANK_W-1:0]      mem_waddr;
    logic [MEM_W-1:0]       mem_wdata;

    assign busy      = (state_reg != ST_IDLE) || clearing_reg;
    assign accept    = start && !busy;
    assign cfg_ready = 1'b1;

    // Clamp n to the number of taxa the memory was sized for.
    assign n_eff = ({1'b0, taxa_count_reg} > N_MAX) ? N_MAX : {1'b0, taxa_count_reg};

    // Sorting network plus validity and topology, all from the held ids.
    always_comb
    begin
        st1[0] = (x_reg[0] < x_reg[1]) ? x_reg[0] : x_reg[1];
        st1[1] = (x_reg[0] < x_reg[1]) ? x_reg[1] : x_reg[0];
        st1[2] = (x_reg[2] < x_reg[3]) ? x_reg[2] : x_reg[3];
        st1[3] = (x_reg[2] < x_reg[3]) ? x_reg[3] : x_reg[2];

        st2[0] = (st1[0] < st1[2]) ? st1[0] : st1[2];
        st2[2] = (st1[0] < st1[2]) ? st1[2] : st1[0];
        st2[1] = (st1[1] < st1[3]) ? st1[1] : st1[3];
        st2[3] = (st1[1] < st1[3]) ? st1[3] : st1[1];

        srt[0] = st2[0];
        srt[1] = (st2[1] < st2[2]) ? st2[1] : st2[2];
        srt[2] = (st2[1] < st2[2]) ? st2[2] : st2[1];
        srt[3] = st2[3];

        // st1 already holds (lo1, hi1, lo2, hi2) of the two pairs
        if ((st1[1] < st1[2]) || (st1[3] < st1[0]))
            topo_comb = TOPO_DISJOINT;
        else if (((st1[0] < st1[2]) && (st1[1] < st1[3])) ||
                 ((st1[0] > st1[2]) && (st1[1] > st1[3])))
            topo_comb = TOPO_INTERLEAVED;
        else
            topo_comb = TOPO_NESTED;

        bad_comb = 1'b0;
        for (int i = 0; i < 4; i++)
        begin
            if ((x_reg[i] == '0) || ({1'b0, x_reg[i]} > n_eff))
                bad_comb = 1'b1;
            for (int j = i + 1; j < 4; j++)
            begin
                if (x_reg[i] == x_reg[j])
                    bad_comb = 1'b1;
            end
        end
    end

    qtvc_rank #(
        .MAX_TAXA (MAX_TAXA)
    ) u_rank (
        .n          (n_eff),
        .sorted_ids (s_reg),
        .rank       (rank_comb)
    );

    // Read-modify-write: bump the voted counter unless it is saturated.
    always_comb
    begin
        for (int i = 0; i < 3; i++)
        begin
            rd_cnt[i]  = rdata_reg[i*COUNT_BITS +: COUNT_BITS];
            new_cnt[i] = rd_cnt[i];
            if ((mode_reg == MODE_RECORD) && (topo_reg == TOPO_W'(i)) &&
                (rd_cnt[i] != COUNT_MAX))
                new_cnt[i] = rd_cnt[i] + 1'b1;
        end
    end

    // Unique maximum, otherwise a tie.
    always_comb
    begin
        if ((cnt_reg[0] > cnt_reg[1]) && (cnt_reg[0] > cnt_reg[2]))
            win_comb = TOPO_DISJOINT;
        else if ((cnt_reg[1] > cnt_reg[0]) && (cnt_reg[1] > cnt_reg[2]))
            win_comb = TOPO_INTERLEAVED;
        else if ((cnt_reg[2] > cnt_reg[0]) && (cnt_reg[2] > cnt_reg[1]))
            win_comb = TOPO_NESTED;
        else
            win_comb = WIN_TIE;
    end

    // The clearing pass and items never overlap, so one write port serves both.
    assign mem_we    = clearing_reg || ((state_reg == ST_MOD) && (mode_reg == MODE_RECORD));
    assign mem_waddr = clearing_reg ? clr_addr_reg : rank_reg;
    assign mem_wdata = clearing_reg ? '0 : {new_cnt[2], new_cnt[1], new_cnt[0]};

    always_ff @(posedge clk)
    begin
        if (mem_we)
            vote_mem[mem_waddr] <= mem_wdata;
        if (state_reg == ST_READ)
            rdata_reg <= vote_mem[rank_reg];
    end

    // Sequencer
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE: if (accept) state_next = ST_SORT;
            ST_SORT: state_next = bad_comb ? ST_OUT : ST_RANK;
            ST_RANK: state_next = ST_READ;
            ST_READ: state_next = ST_MOD;
            ST_MOD:  state_next = ST_OUT;
            ST_OUT:  state_next = ST_IDLE;
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_IDLE;
            clearing_reg   <= 1'b1;
            clr_addr_reg   <= '0;
            taxa_count_reg <= TAXA_COUNT_RESET;
            done_reg       <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            done_reg  <= (state_reg == ST_OUT);
            if (cfg_valid && cfg_ready)
                taxa_count_reg <= cfg_data;
            // Sweep the memory once after reset, then drop busy.
            if (clearing_reg)
            begin
                if (clr_addr_reg == LAST_ENTRY)
                    clearing_reg <= 1'b0;
                else
                    clr_addr_reg <= clr_addr_reg + 1'b1;
            end
        end
    end

    // Payload path: hold the item, then advance it one step per state.
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            mode_reg <= mode;
            x_reg[0] <= taxon_a;
            x_reg[1] <= taxon_b;
            x_reg[2] <= taxon_c;
            x_reg[3] <= taxon_d;
        end
        if (state_reg == ST_SORT)
        begin
            s_reg    <= srt;
            topo_reg <= topo_comb;
            bad_reg  <= bad_comb;
        end
        if (state_reg == ST_RANK)
            rank_reg <= rank_comb;
        if (state_reg == ST_MOD)
            cnt_reg <= new_cnt;
        if (state_reg == ST_OUT)
        begin
            bad_input_reg <= bad_reg;
            if (bad_reg)
            begin
                quartet_rank_reg <= '0;
                topology_reg     <= TOPO_DISJOINT;
                count_first_reg  <= '0;
                count_second_reg <= '0;
                count_third_reg  <= '0;
                winner_reg       <= TOPO_DISJOINT;
            end
            else
            begin
                quartet_rank_reg <= RANK_OUT_W'(rank_reg);
                topology_reg     <= topo_reg;
                count_first_reg  <= CNT_OUT_W'(cnt_reg[0]);
                count_second_reg <= CNT_OUT_W'(cnt_reg[1]);
                count_third_reg  <= CNT_OUT_W'(cnt_reg[2]);
                winner_reg       <= win_comb;
            end
        end
    end

    assign done         = done_reg;
    assign quartet_rank = quartet_rank_reg;
    assign topology     = topology_reg;
    assign count_first  = count_first_reg;
    assign count_second = count_second_reg;
    assign count_third  = count_third_reg;
    assign winner       = winner_reg;
    assign bad_input    = bad_input_reg;

    `QTVC_ASSERT_NEXT(a_done_single, done_reg, !done_reg)
    `QTVC_ASSERT_NEXT(a_no_early_done, accept, !done_reg)
    `QTVC_ASSERT_IMPLIES(a_query_no_write, (state_reg == ST_MOD) && (mode_reg == MODE_QUERY), !mem_we)
    `QTVC_ASSERT_IMPLIES(a_bad_zero, done_reg && bad_input_reg, (count_first_reg == '0) && (winner_reg == TOPO_DISJOINT))
    `QTVC_ASSERT_NEXT(a_clear_holds_idle, clearing_reg, state_reg == ST_IDLE)

endmodule
